// ----- hdl/etd_pkg.sv -----
// Package with widths, the small-prime table and the mod-210 wheel gaps.
`default_nettype none
package etd_pkg;
   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);
   localparam int SMALL_COUNT = 15;
   localparam int SIDX_W = $clog2(SMALL_COUNT);
   localparam int WHEEL_LEN = 48;
   localparam int WIDX_W = $clog2(WHEEL_LEN);

   localparam logic [5:0] SMALL_PRIMES [SMALL_COUNT] = '{
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31,
      6'd37, 6'd41, 6'd43, 6'd47};

   // Gaps between successive residues coprime to 210, starting from 47; 197 is included.
   localparam logic [3:0] WHEEL_GAPS [WHEEL_LEN] = '{
      4'd6, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd6, 4'd4, 4'd6, 4'd8, 4'd4, 4'd2,
      4'd4, 4'd2, 4'd4, 4'd8, 4'd6, 4'd4, 4'd6, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6,
      4'd6, 4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4, 4'd2, 4'd10,
      4'd2, 4'd10, 4'd2, 4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4};

   // Result of one division returned to the sequencer.
   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] quo;
      logic [WIDTH-1:0] rmd;
   } div_rsp_type;
endpackage
`default_nettype wire

// ----- hdl/etd_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module etd_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [etd_pkg::WIDTH-1:0] dividend,
   input  wire logic [etd_pkg::WIDTH-1:0] divisor,
   output etd_pkg::div_rsp_type           rsp
);
   import etd_pkg::*;

   logic [WIDTH-1:0] rmd_ff, rmd_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      trial   = {rmd_ff, quo_ff[WIDTH-1]};
      rmd_in  = rmd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rmd_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rmd_in = WIDTH'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rmd_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDTH-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rmd_ff <= rmd_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) dsr_ff <= divisor;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rmd  = rmd_ff;
endmodule
`default_nettype wire

// ----- hdl/euler_totient_trial_division.sv -----
// Top level: sequencer for totient by trial division over a mod-210 wheel.
// Usage: present n on req_n with req_valid; a transfer happens when req_valid
// and req_ready are both high. req_ready is high only while the sequencer is
// idle, one item at a time. Each trial costs one pass of the shared bit-serial
// divider. An item takes about 15 + (number of wheel candidates tried) + (total
// prime multiplicity) trials; the wheel walk runs up to the square root of the
// largest remaining cofactor, so large primes take the longest.
// n = 0 goes straight to the finish state and answers with phi 0 and bad_input set.
// The result is held in an output register with rsp_valid until the
// receiver takes it; a new item may be accepted while it waits, and a
// finished result stalls in place until the output register is free.
// Synchronous reset returns to idle with no result pending.
`default_nettype none
module euler_totient_trial_division (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [31:0]               req_n,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [31:0]                    rsp_phi,
   output logic                           rsp_bad_input
);
   import etd_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_FINISH} state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] cand_ff, cand_in;
   logic [SIDX_W-1:0] sidx_ff, sidx_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic             small_ff, small_in;
   logic             strip_ff, strip_in;
   logic             bad_ff, bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      phi_ff, phi_in;
   logic             out_bad_ff, out_bad_in;
   logic [WIDTH-1:0] mul_op;
   logic [2*WIDTH-1:0] product;
   logic             start;
   div_rsp_type      div_rsp;

   etd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (rem_ff),
      .divisor  (cand_ff),
      .rsp      (div_rsp)
   );

   assign product = acc_ff * mul_op;

   // Sequencer over the small primes, then the wheel candidates.
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      cand_in      = cand_ff;
      sidx_in      = sidx_ff;
      widx_in      = widx_ff;
      small_in     = small_ff;
      strip_in     = strip_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      phi_in       = phi_ff;
      out_bad_in   = out_bad_ff;
      mul_op       = cand_ff - 1'b1;
      start        = 1'b0;
      req_ready    = (state_ff == S_IDLE);
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rem_in   = req_n[WIDTH-1:0];
               acc_in   = WIDTH'(1);
               cand_in  = WIDTH'(SMALL_PRIMES[0]);
               sidx_in  = '0;
               widx_in  = '0;
               small_in = 1'b1;
               strip_in = 1'b0;
               bad_in   = (req_n[WIDTH-1:0] == '0);
               if (req_n[WIDTH-1:0] == '0) begin
                  acc_in   = '0;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            start    = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               priority if (!small_ff && !strip_ff && (cand_ff > div_rsp.quo)) begin
                  // Candidate beyond the square root: the rest is prime.
                  mul_op   = rem_ff - 1'b1;
                  acc_in   = product[WIDTH-1:0];
                  state_in = S_FINISH;
               end else if (div_rsp.rmd == '0) begin
                  mul_op   = strip_ff ? cand_ff : cand_ff - 1'b1;
                  acc_in   = product[WIDTH-1:0];
                  rem_in   = div_rsp.quo;
                  strip_in = 1'b1;
                  state_in = S_START;
               end else begin
                  strip_in = 1'b0;
                  if (small_ff && (sidx_ff != SIDX_W'(SMALL_COUNT-1))) begin
                     sidx_in = sidx_ff + 1'b1;
                     cand_in = WIDTH'(SMALL_PRIMES[sidx_ff + 1'b1]);
                  end else begin
                     small_in = 1'b0;
                     cand_in  = cand_ff + WIDTH'(WHEEL_GAPS[widx_ff]);
                     widx_in  = (widx_ff == WIDX_W'(WHEEL_LEN-1)) ? '0 : widx_ff + 1'b1;
                  end
                  state_in = (rem_ff == WIDTH'(1)) ? S_FINISH : S_START;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               phi_in       = 32'(acc_ff);
               out_bad_in   = bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      cand_ff    <= cand_in;
      sidx_ff    <= sidx_in;
      widx_ff    <= widx_in;
      small_ff   <= small_in;
      strip_ff   <= strip_in;
      bad_ff     <= bad_in;
      phi_ff     <= phi_in;
      out_bad_ff <= out_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phi       = phi_ff;
   assign rsp_bad_input = out_bad_ff;
endmodule
`default_nettype wire
